[hw/rtl/xfcv_pkg.sv]
// ----------------------------------------------------------------------------
// xfcv_pkg
// Shared types, constants and helper functions of the frame check block.
// ----------------------------------------------------------------------------
package xfcv_pkg;

    // Frame geometry (16-byte frames only)
    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = 5;
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    // Fixed byte positions inside a frame
    localparam logic [POS_W-1:0] POS_MAGIC    = 5'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 5'd1;
    localparam logic [POS_W-1:0] POS_SEQ      = 5'd2;
    localparam logic [POS_W-1:0] POS_CNT_LO   = 5'd4;
    localparam logic [POS_W-1:0] POS_CNT_HI   = 5'd7;
    localparam logic [POS_W-1:0] POS_UPT_LO   = 5'd8;
    localparam logic [POS_W-1:0] POS_UPT_HI   = 5'd11;
    localparam logic [POS_W-1:0] POS_CRC_MSB  = 5'd12;
    localparam logic [POS_W-1:0] POS_CRC_LSB  = 5'd13;
    localparam logic [POS_W-1:0] POS_KEY_END  = 5'd16;
    localparam logic [POS_W:0]   FRAME_LEN    = 6'(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE     = 8'd3;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_LEN   = 3'd1,
        ERR_MAGIC = 3'd2,
        ERR_TYPE  = 3'd3,
        ERR_CRC   = 3'd4
    } t_err_kind;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  magic;
        logic [7:0]  ftype;
    } t_cfg;

    typedef struct packed {
        logic               ok;
        t_err_kind          kind;
        logic [7:0]         seq;
        logic [31:0]        counter;
        logic [31:0]        uptime;
        logic [31:0]        good;
        logic [31:0]        bad;
        logic signed [15:0] rssi;
        logic signed [11:0] snr10;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // One byte of CRC-16/Modbus, LSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Keystream byte for a position: byte 0 in the top bits of key_high
    function automatic logic [7:0] key_byte(input t_cfg cfg, input logic [3:0] pos);
        logic [63:0] w;
        w = pos[3] ? cfg.key_low : cfg.key_high;
        return w[(7 - pos[2:0]) * 8 +: 8];
    endfunction

endpackage

[hw/rtl/xfcv_cfg_regs.sv]
// ----------------------------------------------------------------------------
// xfcv_cfg_regs
// Configuration register file: keystream halves, magic and type bytes.
// ----------------------------------------------------------------------------
module xfcv_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xfcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output xfcv_pkg::t_cfg                 o_cfg
);

    xfcv_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                xfcv_pkg::CFG_KEY_HIGH: r_cfg.key_high <= i_cfg_data;
                xfcv_pkg::CFG_KEY_LOW:  r_cfg.key_low  <= i_cfg_data;
                xfcv_pkg::CFG_MAGIC:    r_cfg.magic    <= i_cfg_data[7:0];
                xfcv_pkg::CFG_TYPE:     r_cfg.ftype    <= i_cfg_data[7:0];
                default: ;  // drop writes beyond the map
            endcase
        end
    end

endmodule

[hw/rtl/xfcv_frame_core.sv]
// ----------------------------------------------------------------------------
// xfcv_frame_core
// Per-byte descramble, CRC update, header checks and frame-end verdict.
// ----------------------------------------------------------------------------
module xfcv_frame_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  xfcv_pkg::t_cfg        i_cfg,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_end_of_frame,
    input  logic signed [15:0]    i_link_rssi,
    input  logic signed [7:0]     i_link_snr,
    output logic                  o_res_valid,
    output xfcv_pkg::t_result     o_res
);

    // Per-frame state
    logic [xfcv_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0]                r_crc, n_crc;
    logic [15:0]                r_rx_crc, n_rx_crc;
    logic [1:0]                 r_flags, n_flags;
    // Shadow fields of the frame in progress (no reset)
    logic [7:0]                 r_sh_seq, n_sh_seq;
    logic [31:0]                r_sh_cnt, n_sh_cnt;
    logic [31:0]                r_sh_upt, n_sh_upt;
    // Committed state
    logic [7:0]                 r_seq, n_seq;
    logic [31:0]                r_cnt, n_cnt;
    logic [31:0]                r_upt, n_upt;
    logic [31:0]                r_good, n_good;
    logic [31:0]                r_bad, n_bad;
    logic signed [15:0]         r_rssi, n_rssi;
    logic signed [11:0]         r_snr, n_snr;

    logic [7:0]                 b;
    logic                       len_ok;
    logic signed [11:0]         snr_ext;
    xfcv_pkg::t_err_kind        kind;

    always_comb begin
        b = i_rx_byte;
        if (r_pos < xfcv_pkg::POS_KEY_END) begin
            b = i_rx_byte ^ xfcv_pkg::key_byte(i_cfg, r_pos[3:0]);
        end

        n_crc    = (r_pos < xfcv_pkg::POS_CRC_MSB) ? xfcv_pkg::crc_feed(r_crc, b) : r_crc;
        n_flags  = r_flags;
        n_rx_crc = r_rx_crc;
        n_sh_seq = r_sh_seq;
        n_sh_cnt = r_sh_cnt;
        n_sh_upt = r_sh_upt;
        if (r_pos == xfcv_pkg::POS_MAGIC && b != i_cfg.magic) n_flags[0] = 1'b1;
        if (r_pos == xfcv_pkg::POS_TYPE && b != i_cfg.ftype)  n_flags[1] = 1'b1;
        if (r_pos == xfcv_pkg::POS_SEQ) n_sh_seq = b;
        if (r_pos >= xfcv_pkg::POS_CNT_LO && r_pos <= xfcv_pkg::POS_CNT_HI) begin
            n_sh_cnt = {r_sh_cnt[23:0], b};
        end
        if (r_pos >= xfcv_pkg::POS_UPT_LO && r_pos <= xfcv_pkg::POS_UPT_HI) begin
            n_sh_upt = {r_sh_upt[23:0], b};
        end
        if (r_pos == xfcv_pkg::POS_CRC_MSB) n_rx_crc[15:8] = b;
        if (r_pos == xfcv_pkg::POS_CRC_LSB) n_rx_crc[7:0]  = b;

        // Frame-end verdict: length, then magic, type, CRC
        len_ok  = ({1'b0, r_pos} + 6'd1) == xfcv_pkg::FRAME_LEN;
        snr_ext = {{4{i_link_snr[7]}}, i_link_snr};
        if (!len_ok)             kind = xfcv_pkg::ERR_LEN;
        else if (n_flags[0])     kind = xfcv_pkg::ERR_MAGIC;
        else if (n_flags[1])     kind = xfcv_pkg::ERR_TYPE;
        else if (n_crc != n_rx_crc) kind = xfcv_pkg::ERR_CRC;
        else                     kind = xfcv_pkg::ERR_NONE;

        n_seq  = r_seq;
        n_cnt  = r_cnt;
        n_upt  = r_upt;
        n_good = r_good;
        n_bad  = r_bad;
        n_rssi = r_rssi;
        n_snr  = r_snr;
        n_pos  = r_pos;
        if (i_end_of_frame) begin
            if (len_ok) begin
                n_rssi = i_link_rssi;
                n_snr  = (snr_ext <<< 3) + (snr_ext <<< 1);
            end
            if (kind == xfcv_pkg::ERR_NONE) begin
                n_seq  = n_sh_seq;
                n_cnt  = n_sh_cnt;
                n_upt  = n_sh_upt;
                n_good = r_good + 32'd1;
            end else begin
                n_bad  = r_bad + 32'd1;
            end
            // restart per-frame state
            n_pos    = '0;
            n_crc    = xfcv_pkg::CRC_INIT;
            n_rx_crc = '0;
            n_flags  = '0;
        end else if (r_pos < xfcv_pkg::POS_MAX) begin
            n_pos = r_pos + 5'd1;
        end

        o_res_valid   = i_accept && i_end_of_frame;
        o_res.ok      = (kind == xfcv_pkg::ERR_NONE);
        o_res.kind    = kind;
        o_res.seq     = n_seq;
        o_res.counter = n_cnt;
        o_res.uptime  = n_upt;
        o_res.good    = n_good;
        o_res.bad     = n_bad;
        o_res.rssi    = n_rssi;
        o_res.snr10   = n_snr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= xfcv_pkg::CRC_INIT;
            r_rx_crc <= '0;
            r_flags  <= '0;
            r_seq    <= '0;
            r_cnt    <= '0;
            r_upt    <= '0;
            r_good   <= '0;
            r_bad    <= '0;
            r_rssi   <= '0;
            r_snr    <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
            r_flags  <= n_flags;
            r_seq    <= n_seq;
            r_cnt    <= n_cnt;
            r_upt    <= n_upt;
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_rssi   <= n_rssi;
            r_snr    <= n_snr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sh_seq <= n_sh_seq;
            r_sh_cnt <= n_sh_cnt;
            r_sh_upt <= n_sh_upt;
        end
    end

endmodule

[hw/rtl/xfcv_out_skid.sv]
// ----------------------------------------------------------------------------
// xfcv_out_skid
// Result register plus one skid entry between the core and the output beat.
// ----------------------------------------------------------------------------
module xfcv_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  xfcv_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    output xfcv_pkg::t_result o_res,
    input  logic              i_ready
);

    logic              r_out_valid;
    xfcv_pkg::t_result r_out;
    logic              r_skd_valid;
    xfcv_pkg::t_result r_skd;

    assign o_space = !r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot frees up: drain skid first
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skd_valid ? r_skd : i_res;
        end else if (i_res_valid) begin
            r_skd <= i_res;
        end
    end

endmodule

[hw/rtl/xor_frame_crc16_validator.sv]
// ----------------------------------------------------------------------------
// xor_frame_crc16_validator
// Descrambles received frame bytes, checks magic, type and CRC-16/Modbus,
// and reports one verdict with link statistics per frame end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Content
//  --------  ---------  -----------------------  -------------------------------
//  s_axis    in         tvalid / tready          one received byte per beat,
//                                                tlast on the last frame byte
//  m_axis    out        tvalid / tready          one verdict beat per frame end
//  cfg       in         i_cfg_valid/o_cfg_ready  register index + 64-bit data
//
//  Throughput: one input beat per cycle while s_axis tready is high. Each byte
//  goes through the key XOR and one byte-wide CRC step in the cycle it is
//  accepted; the verdict of a last byte lands in the result register on that
//  same edge when the output slot is free, else in the skid entry.
//  Stalls: a result register plus one skid entry decouple the sides; s_axis
//  tready drops only while the skid entry is occupied.
//  Reset (i_rst_n low, synchronous): clears the configuration, counters,
//  latched fields and frame position; no clearing pass is needed.
// ----------------------------------------------------------------------------
module xor_frame_crc16_validator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // cfg write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xfcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    // byte stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // rx_byte[7:0], link_rssi[23:8],
                                                          // link_snr[31:24]
    input  logic                           s_axis_tlast,  // end_of_frame
    // verdict out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [167:0]                   m_axis_tdata   // frame_ok[0], error_kind[3:1],
                                                          // last_sequence[11:4],
                                                          // last_counter[43:12],
                                                          // latest_uptime[75:44],
                                                          // good_frames[107:76],
                                                          // bad_frames[139:108],
                                                          // rssi_latched[155:140],
                                                          // snr_times_ten[167:156]
);

    xfcv_pkg::t_cfg    cfg;
    xfcv_pkg::t_result core_res;
    xfcv_pkg::t_result out_res;
    logic              core_res_valid;
    logic              skid_space;
    logic              in_accept;

    assign s_axis_tready = skid_space;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    xfcv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance frame state on every accepted byte
    xfcv_frame_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (in_accept),
        .i_rx_byte      (s_axis_tdata[7:0]),
        .i_end_of_frame (s_axis_tlast),
        .i_link_rssi    (s_axis_tdata[23:8]),
        .i_link_snr     (s_axis_tdata[31:24]),
        .o_res_valid    (core_res_valid),
        .o_res          (core_res)
    );

    // Hold verdicts until the downstream side takes them
    xfcv_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (core_res_valid),
        .i_res       (core_res),
        .o_space     (skid_space),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res),
        .i_ready     (m_axis_tready)
    );

    // Pack the verdict, first field in the lowest bits
    assign m_axis_tdata = {
        out_res.snr10,
        out_res.rssi,
        out_res.bad,
        out_res.good,
        out_res.uptime,
        out_res.counter,
        out_res.seq,
        out_res.kind,
        out_res.ok
    };

endmodule

[hw/rtl/xfcv_checker.sv]
// ----------------------------------------------------------------------------
// xfcv_checker
// Port-level checks of the frame check block, bound to the top level.
// ----------------------------------------------------------------------------
module xfcv_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [167:0] m_axis_tdata
);

    // A held result beat stays valid until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // A fresh result only follows an accepted last byte
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result beat without a frame end");

    // frame_ok agrees with the error kind
    a_ok_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[0] == (m_axis_tdata[3:1] == xfcv_pkg::ERR_NONE)))
        else $error("frame_ok disagrees with error_kind");

    // Only defined error codes are reported
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[3:1] == xfcv_pkg::ERR_NONE  || m_axis_tdata[3:1] == xfcv_pkg::ERR_LEN ||
             m_axis_tdata[3:1] == xfcv_pkg::ERR_MAGIC || m_axis_tdata[3:1] == xfcv_pkg::ERR_TYPE ||
             m_axis_tdata[3:1] == xfcv_pkg::ERR_CRC))
        else $error("undefined error kind");

endmodule

bind xor_frame_crc16_validator xfcv_checker u_xfcv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scrambled-frame CRC-16/Modbus validator. Frames
// are built in plain text, scrambled with the current keystream and streamed
// byte by byte with random gaps on both sides. A bit-accurate predictor of the
// block turns every accepted beat into an expected verdict, and the checker
// compares each verdict beat field by field against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import xfcv_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    localparam int SETTLE_CYCLES = 4;   // quiet time after the last verdict

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [63:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;    // rx_byte, link_rssi, link_snr
    logic                 s_axis_tlast  = 1'b0;  // end_of_frame
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [167:0]         m_axis_tdata;

    xor_frame_crc16_validator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a mirror of the register file and of the frame tracker
    // ------------------------------------------------------------------------
    logic [63:0]        key_high_q  = '0;
    logic [63:0]        key_low_q   = '0;
    logic [7:0]         magic_q     = '0;
    logic [7:0]         ftype_q     = '0;

    logic [POS_W-1:0]   rx_pos      = '0;
    logic [15:0]        crc_run     = CRC_INIT;
    logic [15:0]        crc_rx      = '0;
    logic               magic_bad   = 1'b0;
    logic               type_bad    = 1'b0;
    logic [7:0]         seq_pend    = '0;
    logic [31:0]        count_pend  = '0;
    logic [31:0]        uptime_pend = '0;
    logic [7:0]         seq_q       = '0;
    logic [31:0]        count_q     = '0;
    logic [31:0]        uptime_q    = '0;
    logic [31:0]        good_q      = '0;
    logic [31:0]        bad_q       = '0;
    logic signed [15:0] rssi_q      = '0;
    logic signed [11:0] snr10_q     = '0;

    t_result     verdicts_due[$];
    int unsigned mismatch_count   = 0;
    int unsigned beats_sent       = 0;

    // Idling controls shared by the sender task and the sink process
    bit          src_stall_on     = 1'b0;
    bit          sink_stall_on    = 1'b0;
    int unsigned sink_hold_cycles = 0;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] keystream_byte(input logic [POS_W-1:0] pos);
        logic [63:0] word;
        word = pos[3] ? key_low_q : key_high_q;
        return word[(7 - pos[2:0]) * 8 +: 8];
    endfunction

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Advance the frame tracker by one accepted beat; queue a verdict on tlast
    function automatic void absorb_rx_byte(input logic [7:0] raw, input logic last,
                                           input logic signed [15:0] rssi,
                                           input logic signed [7:0] snr);
        logic [7:0] plain;
        t_err_kind  kind;
        t_result    v;
        plain = raw;
        if (rx_pos < POS_KEY_END) plain = raw ^ keystream_byte(rx_pos);
        if (rx_pos < POS_CRC_MSB) crc_run = modbus_crc_step(crc_run, plain);
        if (rx_pos == POS_MAGIC && plain != magic_q) magic_bad = 1'b1;
        if (rx_pos == POS_TYPE && plain != ftype_q) type_bad = 1'b1;
        if (rx_pos == POS_SEQ) seq_pend = plain;
        if (rx_pos >= POS_CNT_LO && rx_pos <= POS_CNT_HI) count_pend = {count_pend[23:0], plain};
        if (rx_pos >= POS_UPT_LO && rx_pos <= POS_UPT_HI)
            uptime_pend = {uptime_pend[23:0], plain};
        if (rx_pos == POS_CRC_MSB) crc_rx[15:8] = plain;
        if (rx_pos == POS_CRC_LSB) crc_rx[7:0] = plain;

        if (!last) begin
            // Position saturates on overlong frames
            if (rx_pos != POS_MAX) rx_pos = rx_pos + 1'b1;
            return;
        end

        if (({1'b0, rx_pos} + 6'd1) != FRAME_LEN) begin
            kind = ERR_LEN;
        end else begin
            // Link statistics latch only for frames of the right length
            rssi_q  = rssi;
            snr10_q = 12'(int'(snr) * 10);
            if (magic_bad)              kind = ERR_MAGIC;
            else if (type_bad)          kind = ERR_TYPE;
            else if (crc_run != crc_rx) kind = ERR_CRC;
            else                        kind = ERR_NONE;
        end

        if (kind == ERR_NONE) begin
            seq_q    = seq_pend;
            count_q  = count_pend;
            uptime_q = uptime_pend;
            good_q   = good_q + 1;
        end else begin
            bad_q = bad_q + 1;
        end

        v.ok      = (kind == ERR_NONE);
        v.kind    = kind;
        v.seq     = seq_q;
        v.counter = count_q;
        v.uptime  = uptime_q;
        v.good    = good_q;
        v.bad     = bad_q;
        v.rssi    = rssi_q;
        v.snr10   = snr10_q;
        verdicts_due.push_back(v);

        // Per-frame tracker returns to its idle values
        rx_pos    = '0;
        crc_run   = CRC_INIT;
        crc_rx    = '0;
        magic_bad = 1'b0;
        type_bad  = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Verdict checker: compare every accepted output beat
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : verdict_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict beat with no frame end pending: tdata 0x%0h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = verdicts_due.pop_front();
                check_field("frame_ok",      32'(want.ok),      32'(m_axis_tdata[0]));
                check_field("error_kind",    32'(want.kind),    32'(m_axis_tdata[3:1]));
                check_field("last_sequence", 32'(want.seq),     32'(m_axis_tdata[11:4]));
                check_field("last_counter",  want.counter,      m_axis_tdata[43:12]);
                check_field("latest_uptime", want.uptime,       m_axis_tdata[75:44]);
                check_field("good_frames",   want.good,         m_axis_tdata[107:76]);
                check_field("bad_frames",    want.bad,          m_axis_tdata[139:108]);
                check_field("rssi_latched",  {16'h0000, want.rssi},
                            32'(m_axis_tdata[155:140]));
                check_field("snr_times_ten", {20'h00000, want.snr10},
                            32'(m_axis_tdata[167:156]));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Verdict sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : verdict_sink
        int unsigned gap;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                gap = pick_gap();
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one beat, wait for the handshake, then feed it to the predictor.
    // Leave tvalid high on return so back-to-back beats need no extra drive.
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [15:0] rssi, input logic [7:0] snr);
        int unsigned gap;
        if (src_stall_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {snr, rssi, b};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_rx_byte(b, last, rssi, snr);
        beats_sent++;
    endtask

    // Scramble a plain frame with the current keystream and stream it out;
    // only the last beat carries the link statistics that matter
    task automatic send_frame(input t_byte_q plain, input logic [15:0] rssi,
                              input logic [7:0] snr);
        logic [7:0] raw;
        int         i;
        for (i = 0; i < plain.size(); i++) begin
            raw = plain[i];
            if (i < 16) raw = raw ^ keystream_byte(POS_W'(i));
            if (i == plain.size() - 1) send_byte(raw, 1'b1, rssi, snr);
            else                       send_byte(raw, 1'b0, 16'($urandom), 8'($urandom));
        end
    endtask

    // Well-formed plain frame under the current magic and type
    function automatic t_byte_q make_frame(input logic [7:0] seq, input logic [31:0] count,
                                           input logic [31:0] uptime);
        t_byte_q     f;
        logic [15:0] crc;
        int          i;
        f.push_back(magic_q);
        f.push_back(ftype_q);
        f.push_back(seq);
        f.push_back(8'($urandom));
        for (i = 3; i >= 0; i--) f.push_back(count[i*8 +: 8]);
        for (i = 3; i >= 0; i--) f.push_back(uptime[i*8 +: 8]);
        crc = CRC_INIT;
        for (i = 0; i < 12; i++) crc = modbus_crc_step(crc, f[i]);
        f.push_back(crc[15:8]);
        f.push_back(crc[7:0]);
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        return f;
    endfunction

    // Drop valid, wait for every pending verdict, then let the block go quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEY_HIGH: key_high_q = data;
            CFG_KEY_LOW:  key_low_q  = data;
            CFG_MAGIC:    magic_q    = data[7:0];
            CFG_TYPE:     ftype_q    = data[7:0];
            default:      ;   // unmapped index is dropped by the block
        endcase
    endtask

    function automatic logic [15:0] pick_rssi();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_snr();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset configuration (zero key, zero magic and type): a good frame with
    // extreme fields, a one-byte frame, and a frame failing magic, type and CRC
    // at once so that magic wins the error priority
    task automatic test_directed_extremes();
        t_byte_q f;
        src_stall_on  = 1'b0;
        sink_stall_on = 1'b0;
        f = make_frame(8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_frame(f, 16'h8000, 8'h80);
        f = {8'hA5};
        send_frame(f, 16'h7FFF, 8'h7F);
        f = make_frame(8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
        f[0] = 8'hFF;
        f[1] = 8'hFF;
        f[13] = ~f[13];
        send_frame(f, 16'h7FFF, 8'h7F);
        settle_block();
    endtask

    // Hold the sink off for a long stretch while one-byte frames keep coming,
    // so the block fills and stalls its input; then pause until all drain
    task automatic test_backpressure();
        t_byte_q f;
        int      n;
        src_stall_on     = 1'b0;
        sink_stall_on    = 1'b0;
        sink_hold_cycles = 60;
        for (n = 0; n < 24; n++) begin
            f = {8'($urandom)};
            send_frame(f, pick_rssi(), pick_snr());
        end
        settle_block();
    endtask

    // Program one register setting, then stream a mix of frames: mostly
    // well-formed with random content, the rest broken in one way or another
    task automatic test_random_traffic(input logic [63:0] kh, input logic [63:0] kl,
                                       input logic [7:0] magic, input logic [7:0] ftype,
                                       input int unsigned beats);
        t_byte_q     f;
        int unsigned stop_at;
        int unsigned r;
        int unsigned len;
        write_reg(CFG_KEY_HIGH, kh);
        write_reg(CFG_KEY_LOW, kl);
        write_reg(CFG_MAGIC, {56'($urandom), magic});
        write_reg(CFG_TYPE, {56'($urandom), ftype});
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;

        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            // Switch idling on and off so some stretches run flat out
            src_stall_on  = ($urandom_range(0, 2) != 0);
            sink_stall_on = ($urandom_range(0, 2) != 0);
            f = make_frame(8'($urandom), $urandom, $urandom);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // well-formed
            end else if (r < 66) begin
                f[0] = f[0] ^ 8'($urandom_range(1, 255));
            end else if (r < 72) begin
                f[1] = f[1] ^ 8'($urandom_range(1, 255));
            end else if (r < 80) begin
                f[$urandom_range(2, 13)] ^= 8'($urandom_range(1, 255));
            end else if (r < 88) begin
                len = $urandom_range(1, 15);
                while (f.size() > len) void'(f.pop_back());
            end else if (r < 94) begin
                // overlong, past the saturation point at times
                len = $urandom_range(17, 40);
                while (f.size() < len) f.push_back(8'($urandom));
            end else begin
                len = $urandom_range(1, 20);
                f.delete();
                while (f.size() < len) f.push_back(8'($urandom));
            end
            send_frame(f, pick_rssi(), pick_snr());
        end
        settle_block();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : run
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_backpressure();
        test_random_traffic('1, '1, 8'hFF, 8'hFF, 150);
        test_random_traffic('0, '0, 8'h00, 8'h00, 150);
        test_random_traffic({$urandom, $urandom}, {$urandom, $urandom},
                            8'($urandom), 8'($urandom), 200);
        test_random_traffic({$urandom, $urandom}, {$urandom, $urandom},
                            8'($urandom), 8'($urandom), 200);
        test_random_traffic({$urandom, $urandom}, {$urandom, $urandom},
                            8'($urandom), 8'($urandom), 200);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[xor_frame_crc16_validator.f]
hw/rtl/xfcv_pkg.sv
hw/rtl/xfcv_cfg_regs.sv
hw/rtl/xfcv_frame_core.sv
hw/rtl/xfcv_out_skid.sv
hw/rtl/xor_frame_crc16_validator.sv
hw/rtl/xfcv_checker.sv
bench/tb_top.sv
